// ----- rtl/pqmh_pkg.sv -----
// ----------------------------------------------------------------------------
// pqmh_pkg: shared types and constants of the periodic query heap
// Entry layout, status codes, operation codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package pqmh_pkg;

    localparam int DEF_CAPACITY = 1024;

    localparam int ID_W   = 16;
    localparam int PER_W  = 16;
    localparam int TIME_W = 40;
    localparam int STAT_W = 2;

    // Operation codes of an input item.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Status codes of a result item.
    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_POPPED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // One heap entry. The key is {due, id}.
    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  period;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the input item
        logic rd_up;      // read the parent of the hole
        logic rd_root;    // read the root
        logic rd_down;    // read both children of the hole
        logic take_root;  // load the root into the moving entry, record result
        logic place;      // write the moving entry into the hole
        logic step_up;    // move the parent down into the hole
        logic step_down;  // move the smaller child up into the hole
        logic out_load;   // hand the result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic leaf;
        logic up_less;
        logic down_go;
        logic out_free;
    } t_stat;

    function automatic logic key_lt(input t_entry a, input t_entry b);
        return {a.due, a.id} < {b.due, b.id};
    endfunction

endpackage

// ----- rtl/pqmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// pqmh_ctrl: sequencer of the periodic query heap
// Walks an insert up or a pop down the heap one level at a time, through a check and a compare state per level.
// ----------------------------------------------------------------------------
module pqmh_ctrl
    import pqmh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_operation,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_UP_CHK   = 8'b0000_0010,
        S_UP_CMP   = 8'b0000_0100,
        S_POP_RD   = 8'b0000_1000,
        S_POP_ROOT = 8'b0001_0000,
        S_DN_CHK   = 8'b0010_0000,
        S_DN_CMP   = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_operation == OP_INSERT) begin
                        n_state = i_stat.full ? S_FIN : S_UP_CHK;
                    end else begin
                        n_state = i_stat.empty ? S_FIN : S_POP_RD;
                    end
                end
            end
            S_UP_CHK: begin
                if (i_stat.at_root) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    o_cmd.rd_up = 1'b1;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_less) begin
                    o_cmd.step_up = 1'b1;
                    n_state       = S_UP_CHK;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_POP_RD: begin
                o_cmd.rd_root = 1'b1;
                n_state       = S_POP_ROOT;
            end
            S_POP_ROOT: begin
                o_cmd.take_root = 1'b1;
                n_state         = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (i_stat.leaf) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    o_cmd.rd_down = 1'b1;
                    n_state       = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.down_go) begin
                    o_cmd.step_down = 1'b1;
                    n_state         = S_DN_CHK;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/pqmh_dp.sv -----
// ----------------------------------------------------------------------------
// pqmh_dp: datapath of the periodic query heap
// Heap memory, hole position, moving entry, entry count and result registers.
// ----------------------------------------------------------------------------
module pqmh_dp
    import pqmh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_operation,
    input  logic [ID_W-1:0]   i_query_id,
    input  logic [PER_W-1:0]  i_period,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_due_id,
    output logic [TIME_W-1:0] o_due_time
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    t_entry r_heap [CAPACITY];
    t_entry r_rd_a;
    t_entry r_rd_b;
    t_entry r_move;
    t_entry n_move;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     n_pos;
    logic [STAT_W-1:0] r_res_status;
    logic [ID_W-1:0]   r_res_id;
    logic [TIME_W-1:0] r_res_time;
    logic              r_out_valid;

    logic              full;
    logic              empty;
    logic [AW-1:0]     pos_m1;
    logic [AW-1:0]     parent;
    logic [XW-1:0]     left_x;
    logic [XW-1:0]     right_x;
    logic [XW-1:0]     cnt_x;
    logic              left_ok;
    logic              right_ok;
    logic              left_go;
    logic              right_go;
    logic [AW-1:0]     rd_addr_a;
    logic              rd_en;
    logic              wr_en;
    t_entry            wr_data;
    logic [TIME_W:0]   due_sum;
    logic [TIME_W-1:0] due_next;

    assign full    = (r_count == CAP_CNT);
    assign empty   = (r_count == '0);
    assign pos_m1  = r_pos - 1'b1;
    assign parent  = pos_m1 >> 1;
    assign left_x  = {1'b0, r_pos, 1'b1};
    assign right_x = left_x + XW'(1);
    assign cnt_x   = XW'(r_count);
    assign left_ok = (left_x < cnt_x);
    assign right_ok = (right_x < cnt_x);

    // Smaller child wins; on equal children the left one is taken.
    assign left_go  = left_ok && key_lt(r_rd_a, r_move);
    assign right_go = right_ok && key_lt(r_rd_b, r_move)
                      && (!left_go || key_lt(r_rd_b, r_rd_a));

    assign rd_en     = i_cmd.rd_up | i_cmd.rd_root | i_cmd.rd_down;
    assign rd_addr_a = i_cmd.rd_up   ? parent :
                       i_cmd.rd_down ? left_x[AW-1:0] : '0;

    assign wr_en   = i_cmd.place | i_cmd.step_up | i_cmd.step_down;
    assign wr_data = i_cmd.place   ? r_move :
                     i_cmd.step_up ? r_rd_a :
                     (right_go ? r_rd_b : r_rd_a);

    assign due_sum  = {1'b0, r_rd_a.due} + (TIME_W + 1)'(r_rd_a.period);
    assign due_next = due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];

    assign o_stat.full     = full;
    assign o_stat.empty    = empty;
    assign o_stat.at_root  = (r_pos == '0);
    assign o_stat.leaf     = !left_ok;
    assign o_stat.up_less  = key_lt(r_move, r_rd_a);
    assign o_stat.down_go  = left_go | right_go;
    assign o_stat.out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_move  = r_move;
        if (i_cmd.accept) begin
            n_move.due    = TIME_W'(i_period);
            n_move.id     = i_query_id;
            n_move.period = i_period;
            if (i_operation == OP_INSERT) begin
                n_pos = r_count[AW-1:0];
                if (!full) begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                n_pos = '0;
            end
        end
        if (i_cmd.take_root) begin
            n_move.due    = due_next;
            n_move.id     = r_rd_a.id;
            n_move.period = r_rd_a.period;
        end
        if (i_cmd.step_up) begin
            n_pos = parent;
        end
        if (i_cmd.step_down) begin
            n_pos = right_go ? right_x[AW-1:0] : left_x[AW-1:0];
        end
    end

    // Heap storage: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heap[r_pos] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_heap[rd_addr_a];
            r_rd_b <= r_heap[right_x[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_move <= n_move;
        if (i_cmd.accept) begin
            r_res_id   <= '0;
            r_res_time <= '0;
            if (i_operation == OP_INSERT) begin
                r_res_status <= full ? ST_FULL : ST_INSERTED;
            end else begin
                r_res_status <= empty ? ST_EMPTY : ST_POPPED;
            end
        end
        if (i_cmd.take_root) begin
            r_res_id   <= r_rd_a.id;
            r_res_time <= r_rd_a.due;
        end
        if (i_cmd.out_load) begin
            o_status   <= r_res_status;
            o_due_id   <= r_res_id;
            o_due_time <= r_res_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- rtl/periodic_query_min_heap_scheduler.sv -----
// An error item goes straight to its result once accepted; an insert walks the
// entry up and a pop walks it down, one level per check and compare step, at
// most 10 levels for 1024 entries. One item at a time: the next is taken the
// cycle after the result is loaded.
// Reset is synchronous and active low; it empties the heap and the output.
// ----------------------------------------------------------------------------
// periodic_query_min_heap_scheduler: binary min-heap of periodic queries
// Inserts register a query id with its period; pops report the earliest due
// query and reschedule it one period later.
// ----------------------------------------------------------------------------
module periodic_query_min_heap_scheduler
    import pqmh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input item channel.
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_operation,
    input  logic [ID_W-1:0]   i_query_id,
    input  logic [PER_W-1:0]  i_period,
    // Result item channel.
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_due_id,
    output logic [TIME_W-1:0] o_due_time
);

    // The controller sequences each item; the datapath holds the heap memory
    // and the single entry being moved. Instead of swapping, a sift keeps a
    // hole at the current position and moves the other entry into it, so
    // every level needs only one write.
    t_cmd  cmd;
    t_stat stat;

    pqmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The result sits in an output register, so a new item is taken while the
    // previous result still waits for the consumer.
    pqmh_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_operation (i_operation),
        .i_query_id  (i_query_id),
        .i_period    (i_period),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_due_id    (o_due_id),
        .o_due_time  (o_due_time)
    );

endmodule

// ----- rtl/pqmh_checker.sv -----
// ----------------------------------------------------------------------------
// pqmh_checker: port-level checks of the periodic query heap
// Watches the handshakes and result fields at the top level's ports.
// ----------------------------------------------------------------------------
module pqmh_checker
    import pqmh_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [STAT_W-1:0] o_status,
    input logic [ID_W-1:0]   o_due_id,
    input logic [TIME_W-1:0] o_due_time
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A result that is held back keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)
                                  && $stable(o_due_id) && $stable(o_due_time)))
        else $error("stalled result changed");

    // Only a pop reports an id and a due time.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_POPPED)) |-> (o_due_id == '0 && o_due_time == '0))
        else $error("non-pop result carries id or time");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second item accepted back to back");

endmodule

bind periodic_query_min_heap_scheduler pqmh_checker u_pqmh_checker (.*);
